// File: hdl/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and codes for the round robin thread scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

    typedef enum logic [2:0] {
        FUNC_TICK     = 3'd0,
        FUNC_SCHEDULE = 3'd1,
        FUNC_SLEEP    = 3'd2,
        FUNC_WAIT     = 3'd3,
        FUNC_SIGNAL   = 3'd4,
        FUNC_INIT     = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PHASE,
        ST_MOD0,
        ST_MOD1,
        ST_WALK,
        ST_DONE
    } state_t;

    localparam logic CFG_PERIOD_0 = 1'b0;
    localparam logic CFG_PERIOD_1 = 1'b1;

endpackage

// File: hdl/round_robin_thread_scheduler_core.sv
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_core
// Round robin thread scheduler with sleep counters and counting semaphores.
// ----------------------------------------------------------------------------
// One request is handled at a time. Schedule, sleep, wait and signal walk the
// threads one per cycle through a shared index stepper. A tick first reduces
// phase + 1 modulo the larger period and then the new phase modulo each period
// with a shared restoring divider, one quotient bit per cycle. The result sits
// in an output register; the next request is taken once it has been delivered.
module round_robin_thread_scheduler_core #(
    parameter int THREADS         = 6,
    parameter int SEMAPHORES      = 4,
    parameter int PERIODIC_EVENTS = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // func[2:0], sleep_time[34:3], sem_index[36:35], sem_value[68:37], zero pad
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // running_thread[2:0], none_ready[3], fire_mask[5:4], suspended[6],
    // sem_count[38:7], zero pad
    output logic [39:0] m_tdata
);
    import rrts_pkg::*;

    localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int BW = $clog2(SEMAPHORES + 1);

    state_t state_reg, state_next;

    logic [31:0] period_reg [2];
    logic [TW-1:0] cur_reg;
    logic [31:0] sleep_reg [THREADS];
    logic [BW-1:0] blk_reg [THREADS];
    logic [31:0] sem_reg [SEMAPHORES];
    logic [31:0] phase_reg;

    logic [2:0]  func_reg;
    logic [31:0] sval_reg;
    logic [1:0]  sidx_reg;
    logic [TW-1:0] t_reg;
    logic [3:0]  cnt_reg;
    logic [5:0]  bit_reg;
    logic [32:0] rem_reg;
    logic [32:0] num_reg;
    logic        mode_reg;

    logic        out_valid_reg;
    logic [2:0]  o_thr_reg;
    logic        o_nr_reg, o_susp_reg;
    logic [1:0]  o_fire_reg;
    logic [31:0] o_cnt_reg;

    logic [31:0] p0, p1, pm, div_p;
    logic [TW-1:0] t_inc;
    logic        dbit;
    logic [32:0] trial;
    logic [32:0] rem_step;
    logic [31:0] sem_dec, sem_inc;
    logic [BW-1:0] sem_tag;
    logic        idx_ok;

    assign p0 = (period_reg[0] == 32'd0) ? 32'd1 : period_reg[0];
    assign p1 = (period_reg[1] == 32'd0) ? 32'd1 : period_reg[1];
    assign pm = (PERIODIC_EVENTS >= 2 && p1 > p0) ? p1 : p0;
    assign t_inc = (32'(t_reg) == THREADS - 1) ? '0 : TW'(32'(t_reg) + 1);
    assign sem_tag = BW'(32'(sidx_reg) + 1);
    assign idx_ok = 32'(sidx_reg) < SEMAPHORES;
    assign sem_dec = sem_reg[sidx_reg] - 32'd1;
    assign sem_inc = sem_reg[sidx_reg] + 32'd1;
    always_comb
    begin
        case (state_reg)
            ST_PHASE: div_p = pm;
            ST_MOD1:  div_p = p1;
            default:  div_p = p0;
        endcase
    end
    assign dbit     = (state_reg == ST_PHASE) ? num_reg[bit_reg] : phase_reg[bit_reg[4:0]];
    assign trial    = {rem_reg[31:0], dbit};
    assign rem_step = (trial >= {1'b0, div_p}) ? trial - {1'b0, div_p} : trial;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_tready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {1'b0, o_cnt_reg, o_susp_reg, o_fire_reg, o_nr_reg, o_thr_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    case (s_tdata[2:0])
                        FUNC_TICK:     state_next = ST_PHASE;
                        FUNC_SCHEDULE: state_next = ST_WALK;
                        FUNC_SLEEP:    state_next = ST_WALK;
                        FUNC_WAIT:     state_next = ST_WALK;
                        FUNC_SIGNAL:   state_next = ST_WALK;
                        FUNC_INIT:     state_next = ST_WALK;
                        default:       state_next = ST_DONE;
                    endcase
                end
            end
            ST_PHASE: if (bit_reg == 6'd0) state_next = ST_MOD0;
            ST_MOD0:  if (bit_reg == 6'd0)
                          state_next = (PERIODIC_EVENTS >= 2) ? ST_MOD1 : ST_DONE;
            ST_MOD1:  if (bit_reg == 6'd0) state_next = ST_DONE;
            ST_WALK:  state_next = ST_WALK;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            period_reg[0] <= 32'd1;
            period_reg[1] <= 32'd1;
            cur_reg       <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < THREADS; i++)
            begin
                sleep_reg[i] <= '0;
                blk_reg[i]   <= '0;
            end
            for (int i = 0; i < SEMAPHORES; i++)
                sem_reg[i] <= '0;
        end
        else
        begin
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_PERIOD_0) period_reg[0] <= cfg_data;
                else                           period_reg[1] <= cfg_data;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    state_reg <= state_next;
                    if (s_tvalid && s_tready)
                    begin
                        func_reg   <= s_tdata[2:0];
                        sidx_reg   <= s_tdata[36:35];
                        sval_reg   <= s_tdata[68:37];
                        t_reg      <= cur_reg;
                        cnt_reg    <= '0;
                        o_nr_reg   <= 1'b0;
                        o_fire_reg <= '0;
                        o_susp_reg <= (s_tdata[2:0] == FUNC_SLEEP) && (s_tdata[34:3] != 32'd0);
                        o_cnt_reg  <= '0;
                        mode_reg   <= (s_tdata[2:0] == FUNC_SCHEDULE) ||
                                      (s_tdata[2:0] == FUNC_SLEEP);
                        num_reg    <= {1'b0, phase_reg} + 33'd1;
                        bit_reg    <= 6'd32;
                        rem_reg    <= '0;
                        if (s_tdata[2:0] == FUNC_TICK)
                        begin
                            for (int i = 0; i < THREADS; i++)
                                if (sleep_reg[i] != 0) sleep_reg[i] <= sleep_reg[i] - 32'd1;
                        end
                        else if (s_tdata[2:0] == FUNC_SLEEP)
                            sleep_reg[cur_reg] <= s_tdata[34:3];
                    end
                end
                ST_PHASE:
                begin
                    if (bit_reg == 6'd0)
                    begin
                        state_reg <= state_next;
                        phase_reg <= rem_step[31:0];
                        rem_reg   <= '0;
                        bit_reg   <= 6'd31;
                    end
                    else
                    begin
                        rem_reg <= rem_step;
                        bit_reg <= bit_reg - 6'd1;
                    end
                end
                ST_MOD0, ST_MOD1:
                begin
                    if (bit_reg == 6'd0)
                    begin
                        state_reg <= state_next;
                        rem_reg   <= '0;
                        bit_reg   <= 6'd31;
                        if (rem_step == 33'd0)
                            o_fire_reg[state_reg == ST_MOD1] <= 1'b1;
                    end
                    else
                    begin
                        rem_reg <= rem_step;
                        bit_reg <= bit_reg - 6'd1;
                    end
                end
                ST_WALK:
                begin
                    if (!mode_reg && cnt_reg == 0)
                    begin
                        // semaphore operations begin here
                        if (!idx_ok)
                            state_reg <= ST_DONE;
                        else
                        begin
                            case (func_reg)
                                FUNC_WAIT:
                                begin
                                    sem_reg[sidx_reg] <= sem_dec;
                                    o_cnt_reg <= sem_dec;
                                    if (sem_dec[31])
                                    begin
                                        blk_reg[cur_reg] <= sem_tag;
                                        o_susp_reg <= 1'b1;
                                        mode_reg   <= 1'b1;
                                    end
                                    else
                                        state_reg <= ST_DONE;
                                end
                                FUNC_SIGNAL:
                                begin
                                    sem_reg[sidx_reg] <= sem_inc;
                                    o_cnt_reg <= sem_inc;
                                    if (sem_inc == 32'd0 || sem_inc[31])
                                        cnt_reg <= 4'd1;
                                    else
                                        state_reg <= ST_DONE;
                                end
                                default:
                                begin
                                    sem_reg[sidx_reg] <= sval_reg;
                                    o_cnt_reg <= sval_reg;
                                    state_reg <= ST_DONE;
                                end
                            endcase
                        end
                    end
                    else if (!mode_reg)
                    begin
                        // signal: find first waiter after current thread
                        t_reg   <= t_inc;
                        cnt_reg <= cnt_reg + 4'd1;
                        if (blk_reg[t_inc] == sem_tag)
                        begin
                            blk_reg[t_inc] <= '0;
                            state_reg <= ST_DONE;
                        end
                        else if (32'(cnt_reg) == THREADS)
                            state_reg <= ST_DONE;
                    end
                    else
                    begin
                        t_reg   <= t_inc;
                        cnt_reg <= cnt_reg + 4'd1;
                        if (sleep_reg[t_inc] == 0 && blk_reg[t_inc] == 0)
                        begin
                            cur_reg   <= t_inc;
                            state_reg <= ST_DONE;
                        end
                        else if (32'(cnt_reg) == THREADS - 1)
                        begin
                            o_nr_reg  <= 1'b1;
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_DONE:
                begin
                    o_thr_reg     <= 3'(cur_reg);
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: hdl/rrts_checker.sv
// ----------------------------------------------------------------------------
// rrts_checker
// Port level checks for the round robin thread scheduler.
// ----------------------------------------------------------------------------
module rrts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("request taken with result pending");
    a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready && !m_tvalid)
        else $error("request finished in zero cycles");
    a_thread_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= 3'd5)
        else $error("thread out of range");
endmodule

bind round_robin_thread_scheduler_core rrts_checker u_rrts_checker (.*);

// File: verif/round_robin_thread_scheduler_core_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_core_chk
// Predicts scheduler responses from observed requests and register writes and
// compares each response field by field, oldest first.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_core_chk #(
    parameter int THREADS         = 6,
    parameter int SEMAPHORES      = 4,
    parameter int PERIODIC_EVENTS = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    output int          errors,
    output int          pending
);
    import rrts_pkg::*;

    typedef struct packed {
        logic [31:0] sem_count;
        logic        suspended;
        logic [1:0]  fire_mask;
        logic        none_ready;
        logic [2:0]  running_thread;
    } resp_t;

    logic [31:0] period [2];
    logic [2:0]  cur_thread;
    logic [31:0] sleep_left [THREADS];
    logic [2:0]  blocked_on [THREADS];
    logic [31:0] sem_val [SEMAPHORES];
    logic [31:0] phase;
    resp_t       resp_q [$];

    function automatic logic [31:0] eff(logic [31:0] p);
        return (p == 0) ? 32'd1 : p;
    endfunction

    function automatic logic pick_next();
        int t;
        t = cur_thread;
        for (int k = 0; k < THREADS; k++) begin
            t = (t + 1) % THREADS;
            if (sleep_left[t] == 0 && blocked_on[t] == 0) begin
                cur_thread = t;
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic resp_t run_request(logic [71:0] d);
        func_t       fn;
        logic [31:0] stime;
        logic [1:0]  sidx;
        logic [31:0] p0;
        logic [31:0] p1;
        logic [31:0] m;
        int          t;
        resp_t       r;
        fn    = func_t'(d[2:0]);
        stime = d[34:3];
        sidx  = d[36:35];
        r     = '0;
        if (fn == FUNC_TICK) begin
            p0 = eff(period[0]);
            p1 = eff(period[1]);
            m  = (PERIODIC_EVENTS >= 2 && p1 > p0) ? p1 : p0;
            for (int i = 0; i < THREADS; i++)
                if (sleep_left[i] != 0)
                    sleep_left[i] = sleep_left[i] - 1;
            phase = 32'((64'(phase) + 1) % 64'(m));
            r.fire_mask[0] = (phase % p0) == 0;
            if (PERIODIC_EVENTS >= 2)
                r.fire_mask[1] = (phase % p1) == 0;
        end else if (fn == FUNC_SCHEDULE) begin
            r.none_ready = pick_next();
        end else if (fn == FUNC_SLEEP) begin
            sleep_left[cur_thread] = stime;
            r.suspended = stime != 0;
            r.none_ready = pick_next();
        end else if ((fn == FUNC_WAIT || fn == FUNC_SIGNAL || fn == FUNC_INIT)
                     && sidx < SEMAPHORES) begin
            if (fn == FUNC_WAIT) begin
                sem_val[sidx] = sem_val[sidx] - 1;
                if (sem_val[sidx][31]) begin
                    blocked_on[cur_thread] = sidx + 1;
                    r.suspended = 1'b1;
                    r.none_ready = pick_next();
                end
            end else if (fn == FUNC_SIGNAL) begin
                sem_val[sidx] = sem_val[sidx] + 1;
                if (sem_val[sidx] == 0 || sem_val[sidx][31]) begin
                    t = cur_thread;
                    for (int i = 0; i < THREADS; i++) begin
                        t = (t + 1) % THREADS;
                        if (blocked_on[t] == sidx + 1) begin
                            blocked_on[t] = 0;
                            break;
                        end
                    end
                end
            end else begin
                sem_val[sidx] = d[68:37];
            end
            r.sem_count = sem_val[sidx];
        end
        r.running_thread = cur_thread;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        resp_t e;
        resp_t a;
        if (!rst_n) begin
            period[0]  = 1;
            period[1]  = 1;
            cur_thread = 0;
            phase      = 0;
            for (int i = 0; i < THREADS; i++) begin
                sleep_left[i] = 0;
                blocked_on[i] = 0;
            end
            for (int i = 0; i < SEMAPHORES; i++)
                sem_val[i] = 0;
            resp_q.delete();
            errors  = 0;
            pending = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                period[cfg_index] = cfg_data;
            if (s_tvalid && s_tready)
                resp_q.push_back(run_request(s_tdata));
            if (m_tvalid && m_tready) begin
                a = resp_t'(m_tdata[38:0]);
                if (resp_q.size() == 0) begin
                    errors++;
                    $error("unexpected response %h", m_tdata);
                end else begin
                    e = resp_q.pop_front();
                    if (a.running_thread !== e.running_thread) begin
                        errors++;
                        $error("running_thread exp %0d got %0d",
                               e.running_thread, a.running_thread);
                    end
                    if (a.none_ready !== e.none_ready) begin
                        errors++;
                        $error("none_ready exp %0d got %0d", e.none_ready, a.none_ready);
                    end
                    if (a.fire_mask !== e.fire_mask) begin
                        errors++;
                        $error("fire_mask exp %0d got %0d", e.fire_mask, a.fire_mask);
                    end
                    if (a.suspended !== e.suspended) begin
                        errors++;
                        $error("suspended exp %0d got %0d", e.suspended, a.suspended);
                    end
                    if (a.sem_count !== e.sem_count) begin
                        errors++;
                        $error("sem_count exp %0d got %0d",
                               $signed(e.sem_count), $signed(a.sem_count));
                    end
                end
            end
            pending = resp_q.size();
        end
    end

endmodule

// File: verif/round_robin_thread_scheduler_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_core_tb
// Drives directed and random scheduler requests and period settings with
// random gaps and response stalls; a checker predicts and compares.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_core_tb;
    import rrts_pkg::*;

    localparam int WATCHDOG = 20000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = CFG_PERIOD_0;
    logic [31:0] cfg_data = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [71:0] s_tdata = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;
    int          errors;
    int          pending;
    int          idle_cycles = 0;
    bit          quiet = 0;
    logic [31:0] p0s [4] = '{32'd0, 32'd3, 32'd7, 32'hFFFF_FFFF};
    logic [31:0] p1s [4] = '{32'd5, 32'd0, 32'hFFFF_FFFF, 32'd2};

    always #10 clk = ~clk;

    round_robin_thread_scheduler_core u_top (.*);

    round_robin_thread_scheduler_core_chk u_chk (.*);

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // response stalls
    initial begin
        int n;
        forever begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 9) == 0) begin
                m_tready <= 0;
                n = $urandom_range(1, 13);
                repeat (n) @(negedge clk);
            end
            m_tready <= 1;
        end
    end

    task automatic write_period(logic [0:0] idx, logic [31:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 0;
        @(negedge clk);
    endtask

    // s_tvalid stays high after a request until the next gap or drain
    task automatic send_op(func_t fn, logic [31:0] stime, logic [1:0] sidx,
                           logic [31:0] sval);
        int n;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 0;
            n = $urandom_range(1, 13);
            repeat (n) @(negedge clk);
        end
        s_tdata  <= {3'b0, sval, sidx, stime, fn};
        s_tvalid <= 1;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic random_op();
        int          r;
        logic [31:0] st;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0)
            st = $urandom();
        else
            st = $urandom_range(0, 6);
        if (r < 30)
            send_op(FUNC_TICK, $urandom(), 2'($urandom()), $urandom());
        else if (r < 42)
            send_op(FUNC_SCHEDULE, $urandom(), 2'($urandom()), $urandom());
        else if (r < 54)
            send_op(FUNC_SLEEP, st, 2'($urandom()), $urandom());
        else if (r < 70)
            send_op(FUNC_WAIT, $urandom(), 2'($urandom()), $urandom());
        else if (r < 88)
            send_op(FUNC_SIGNAL, $urandom(), 2'($urandom()), $urandom());
        else if (r < 97)
            send_op(FUNC_INIT, $urandom(), 2'($urandom()),
                    $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 3) - 1);
        else
            send_op(func_t'($urandom_range(6, 7)), $urandom(), 2'($urandom()), $urandom());
    endtask

    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed
        send_op(FUNC_TICK, 0, 2'd0, 0);
        send_op(FUNC_INIT, 0, 2'd3, 32'h7FFF_FFFF);
        send_op(FUNC_SIGNAL, 0, 2'd3, 0);
        send_op(FUNC_INIT, 0, 2'd0, 32'h8000_0000);
        send_op(FUNC_WAIT, 0, 2'd0, 0);
        send_op(FUNC_INIT, 0, 2'd1, 0);
        send_op(FUNC_SLEEP, 32'hFFFF_FFFF, 2'd0, 0);
        send_op(FUNC_SLEEP, 0, 2'd0, 0);
        for (int i = 0; i < 6; i++)
            send_op(FUNC_WAIT, 0, 2'd1, 0);
        send_op(FUNC_SCHEDULE, 0, 2'd0, 0);
        send_op(FUNC_SIGNAL, 0, 2'd2, 0);
        for (int i = 0; i < 6; i++)
            send_op(FUNC_SIGNAL, 0, 2'd1, 0);
        send_op(func_t'(3'd6), 32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF);
        send_op(func_t'(3'd7), 0, 2'd0, 0);
        send_op(FUNC_SCHEDULE, 0, 2'd0, 0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            write_period(CFG_PERIOD_0, p0s[ph]);
            write_period(CFG_PERIOD_1, p1s[ph]);
            if (ph == 3)
                quiet = 1;
            for (int i = 0; i < 345; i++)
                random_op();
            drain();
        end

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
